@@ hw/rtl/amor_pkg.sv @@
`default_nettype none

package amor_pkg;

    // field widths
    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 31;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = SIZE_W + SCALE_W;
    // Q16.16 * Q8.8 back to Q16.16 is /256, half extent is a further /2
    localparam int HALF_SHIFT = 9;
    localparam int HALF_W     = PROD_W - HALF_SHIFT;
    localparam int EXT_W      = HALF_W + 2;
    localparam int DIST_W     = COORD_W;
    localparam int PUSH_W     = DIST_W + 1;
    localparam int SIDE_W     = 3;

    // contact side codes
    typedef enum logic [SIDE_W-1:0] {
        SIDE_NONE   = 3'd0,
        SIDE_TOP    = 3'd1,
        SIDE_BOTTOM = 3'd2,
        SIDE_LEFT   = 3'd3,
        SIDE_RIGHT  = 3'd4,
        SIDE_FRONT  = 3'd5,
        SIDE_BACK   = 3'd6
    } side_t;

    // saturated box bounds
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } bounds_t;

endpackage

`default_nettype wire

@@ hw/rtl/amor_if.sv @@
`default_nettype none

// box request channel
interface amor_box_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  box_role;
    logic signed [amor_pkg::COORD_W-1:0]   pos_x;
    logic signed [amor_pkg::COORD_W-1:0]   pos_y;
    logic signed [amor_pkg::COORD_W-1:0]   pos_z;
    logic [amor_pkg::SIZE_W-1:0]           depth_x;
    logic [amor_pkg::SIZE_W-1:0]           width_y;
    logic [amor_pkg::SIZE_W-1:0]           height_z;
    logic [amor_pkg::SCALE_W-1:0]          scale_x;
    logic [amor_pkg::SCALE_W-1:0]          scale_y;
    logic [amor_pkg::SCALE_W-1:0]          scale_z;

    modport source (
        output valid, box_role, pos_x, pos_y, pos_z,
        output depth_x, width_y, height_z, scale_x, scale_y, scale_z,
        input  ready
    );
    modport sink (
        input  valid, box_role, pos_x, pos_y, pos_z,
        input  depth_x, width_y, height_z, scale_x, scale_y, scale_z,
        output ready
    );
endinterface

// contact result channel
interface amor_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [amor_pkg::SIDE_W-1:0]           hit_side;
    logic signed [amor_pkg::PUSH_W-1:0]    push_x;
    logic signed [amor_pkg::PUSH_W-1:0]    push_y;
    logic signed [amor_pkg::PUSH_W-1:0]    push_z;

    modport source (
        output valid, hit_side, push_x, push_y, push_z,
        input  ready
    );
    modport sink (
        input  valid, hit_side, push_x, push_y, push_z,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/amor_box_bounds.sv @@
`default_nettype none

module amor_box_bounds (
    input  wire logic signed [amor_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [amor_pkg::COORD_W-1:0] pos_y,
    input  wire logic signed [amor_pkg::COORD_W-1:0] pos_z,
    input  wire logic [amor_pkg::HALF_W-1:0]         half_x,
    input  wire logic [amor_pkg::HALF_W-1:0]         half_y,
    input  wire logic [amor_pkg::HALF_W-1:0]         half_z,
    output amor_pkg::bounds_t                        bounds
);

    localparam int CW = amor_pkg::COORD_W;
    localparam int EW = amor_pkg::EXT_W;
    localparam int HW = amor_pkg::HALF_W;

    // clamp a wide signed value into the 32-bit coordinate range
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [EW-1:0] v);
        logic [EW-CW:0] top;
        top = v[EW-1:CW-1];
        if (top == '0 || top == '1)
            return v[CW-1:0];
        else if (v[EW-1])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    // centre minus or plus half extent, both saturated
    function automatic logic signed [CW-1:0] lower(
        input logic signed [CW-1:0] c,
        input logic [HW-1:0]        h
    );
        logic signed [EW-1:0] ce;
        logic signed [EW-1:0] he;
        ce = {{(EW-CW){c[CW-1]}}, c};
        he = {{(EW-HW){1'b0}}, h};
        return sat_coord(ce - he);
    endfunction

    function automatic logic signed [CW-1:0] upper(
        input logic signed [CW-1:0] c,
        input logic [HW-1:0]        h
    );
        logic signed [EW-1:0] ce;
        logic signed [EW-1:0] he;
        ce = {{(EW-CW){c[CW-1]}}, c};
        he = {{(EW-HW){1'b0}}, h};
        return sat_coord(ce + he);
    endfunction

    always_comb
    begin
        bounds.min_x = lower(pos_x, half_x);
        bounds.min_y = lower(pos_y, half_y);
        bounds.min_z = lower(pos_z, half_z);
        bounds.max_x = upper(pos_x, half_x);
        bounds.max_y = upper(pos_y, half_y);
        bounds.max_z = upper(pos_z, half_z);
    end

endmodule

`default_nettype wire

@@ hw/rtl/aabb_min_overlap_resolver_unit.sv @@
`default_nettype none

// channel   dir  payload                                              handshake
// box       in   box_role, pos_x/y/z, depth_x, width_y, height_z,     valid/ready
//                scale_x/y/z
// result    out  hit_side, push_x/y/z (one per obstacle request)      valid/ready
//
// Five-stage pipeline: input register, half-extent multiply, bounds, face
// distances, result register. One request per cycle while the result side does
// not stall; a stage advances only when the stage after it is free to move.
// Reset clears all stage valids and the stored mover box to a point at origin.
// A stalled result holds its stage; empty stages ahead of it keep filling, and
// ready drops only once the input register itself cannot move.

module aabb_min_overlap_resolver_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    amor_box_if.sink            box,
    amor_result_if.source       result
);

    localparam int CW = amor_pkg::COORD_W;
    localparam int DW = amor_pkg::DIST_W;
    localparam int PW = amor_pkg::PUSH_W;
    localparam int HW = amor_pkg::HALF_W;

    // absolute distance between two bounds
    function automatic logic [DW-1:0] abs_dist(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        if (d[CW])
            d = -d;
        return d[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] min2(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return (b < a) ? b : a;
    endfunction

    // stage flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic free1, free2, free3, free4, free5;

    assign free5 = !v5_reg || result.ready;
    assign free4 = !v4_reg || free5;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign box.ready = free1;

    // stage payloads
    logic                    role1_reg;
    logic signed [CW-1:0]    pos1_reg [3];
    logic [amor_pkg::SIZE_W-1:0]  size1_reg [3];
    logic [amor_pkg::SCALE_W-1:0] scale1_reg [3];

    logic                    role2_reg;
    logic signed [CW-1:0]    pos2_reg [3];
    logic [HW-1:0]           half2_reg [3];
    logic [HW-1:0]           half2_next [3];

    logic                    role3_reg;
    amor_pkg::bounds_t       bounds3_reg;
    amor_pkg::bounds_t       bounds3_next;

    amor_pkg::bounds_t       mover_reg;

    logic                    hit4_reg;
    logic                    hit4_next;
    logic [DW-1:0]           dist4_reg [6];
    logic [DW-1:0]           dist4_next [6];

    amor_pkg::side_t         side5_reg;
    amor_pkg::side_t         side5_next;
    logic signed [PW-1:0]    push_x5_reg, push_y5_reg, push_z5_reg;
    logic signed [PW-1:0]    push_x5_next, push_y5_next, push_z5_next;

    // valid bits and mover store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            mover_reg <= '0;
        end
        else
        begin
            if (free1)
                v1_reg <= box.valid;
            if (free2)
                v2_reg <= v1_reg;
            if (free3)
                v3_reg <= v2_reg;
            if (free4)
            begin
                v4_reg <= v3_reg && role3_reg;
                if (v3_reg && !role3_reg)
                    mover_reg <= bounds3_reg;
            end
            if (free5)
                v5_reg <= v4_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (box.valid && free1)
        begin
            role1_reg     <= box.box_role;
            pos1_reg[0]   <= box.pos_x;
            pos1_reg[1]   <= box.pos_y;
            pos1_reg[2]   <= box.pos_z;
            size1_reg[0]  <= box.depth_x;
            size1_reg[1]  <= box.width_y;
            size1_reg[2]  <= box.height_z;
            scale1_reg[0] <= box.scale_x;
            scale1_reg[1] <= box.scale_y;
            scale1_reg[2] <= box.scale_z;
        end
    end

    // half extents: size * scale / 512
    always_comb
    begin
        logic [amor_pkg::PROD_W-1:0] prod;
        for (int a = 0; a < 3; a++)
        begin
            prod = {{amor_pkg::SCALE_W{1'b0}}, size1_reg[a]}
                 * {{amor_pkg::SIZE_W{1'b0}}, scale1_reg[a]};
            half2_next[a] = prod[amor_pkg::PROD_W-1:amor_pkg::HALF_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && free2)
        begin
            role2_reg <= role1_reg;
            pos2_reg  <= pos1_reg;
            half2_reg <= half2_next;
        end
    end

    // box bounds
    amor_box_bounds u_bounds (
        .pos_x  (pos2_reg[0]),
        .pos_y  (pos2_reg[1]),
        .pos_z  (pos2_reg[2]),
        .half_x (half2_reg[0]),
        .half_y (half2_reg[1]),
        .half_z (half2_reg[2]),
        .bounds (bounds3_next)
    );

    always_ff @(posedge clk)
    begin
        if (v2_reg && free3)
        begin
            role3_reg   <= role2_reg;
            bounds3_reg <= bounds3_next;
        end
    end

    // overlap test and face distances against the stored mover
    always_comb
    begin
        hit4_next = !(mover_reg.max_x < bounds3_reg.min_x ||
                      mover_reg.max_y < bounds3_reg.min_y ||
                      mover_reg.max_z < bounds3_reg.min_z ||
                      bounds3_reg.max_x < mover_reg.min_x ||
                      bounds3_reg.max_y < mover_reg.min_y ||
                      bounds3_reg.max_z < mover_reg.min_z);
        dist4_next[0] = abs_dist(bounds3_reg.max_z, mover_reg.min_z);
        dist4_next[1] = abs_dist(bounds3_reg.min_z, mover_reg.max_z);
        dist4_next[2] = abs_dist(bounds3_reg.min_y, mover_reg.max_y);
        dist4_next[3] = abs_dist(bounds3_reg.max_y, mover_reg.min_y);
        dist4_next[4] = abs_dist(bounds3_reg.max_x, mover_reg.min_x);
        dist4_next[5] = abs_dist(bounds3_reg.min_x, mover_reg.max_x);
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && role3_reg && free4)
        begin
            hit4_reg  <= hit4_next;
            dist4_reg <= dist4_next;
        end
    end

    // minimum distance and side pick, later checks override earlier ties
    always_comb
    begin
        logic [DW-1:0] m;
        m = min2(min2(min2(dist4_reg[0], dist4_reg[1]), min2(dist4_reg[2], dist4_reg[3])),
                 min2(dist4_reg[4], dist4_reg[5]));
        side5_next   = amor_pkg::SIDE_NONE;
        push_x5_next = '0;
        push_y5_next = '0;
        push_z5_next = '0;
        if (hit4_reg)
        begin
            if (dist4_reg[0] == m)
            begin
                push_z5_next = -$signed({1'b0, dist4_reg[0]});
                side5_next   = amor_pkg::SIDE_TOP;
            end
            if (dist4_reg[1] == m)
            begin
                push_z5_next = $signed({1'b0, dist4_reg[1]});
                side5_next   = amor_pkg::SIDE_BOTTOM;
            end
            if (dist4_reg[2] == m)
            begin
                push_y5_next = -$signed({1'b0, dist4_reg[2]});
                side5_next   = amor_pkg::SIDE_LEFT;
            end
            if (dist4_reg[3] == m)
            begin
                push_y5_next = $signed({1'b0, dist4_reg[3]});
                side5_next   = amor_pkg::SIDE_RIGHT;
            end
            if (dist4_reg[4] == m)
            begin
                push_x5_next = $signed({1'b0, dist4_reg[4]});
                side5_next   = amor_pkg::SIDE_FRONT;
            end
            if (dist4_reg[5] == m)
            begin
                push_x5_next = $signed({1'b0, dist4_reg[5]});
                side5_next   = amor_pkg::SIDE_BACK;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (v4_reg && free5)
        begin
            side5_reg   <= side5_next;
            push_x5_reg <= push_x5_next;
            push_y5_reg <= push_y5_next;
            push_z5_reg <= push_z5_next;
        end
    end

    assign result.valid    = v5_reg;
    assign result.hit_side = side5_reg;
    assign result.push_x   = push_x5_reg;
    assign result.push_y   = push_y5_reg;
    assign result.push_z   = push_z5_reg;

    // a miss carries no offset
    a_miss_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit_side == amor_pkg::SIDE_NONE |->
            result.push_x == '0 && result.push_y == '0 && result.push_z == '0)
        else $error("miss result with nonzero push");

    // a mover request never turns into a result
    a_mover_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !role3_reg && free4 |=> !v4_reg)
        else $error("mover request entered distance stage");

    // the stored mover changes only when a mover leaves the bounds stage
    a_mover_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(mover_reg) |-> $past(v3_reg && !role3_reg && free4))
        else $error("mover bounds changed without a mover request");

    // input stalls only with a full input register
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !box.ready |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
        else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

@@ dv/amor_tb_pkg.sv @@
`timescale 1ns / 1ps

package amor_tb_pkg;

    // box request roles
    typedef enum logic {
        ROLE_MOVER    = 1'b0,
        ROLE_OBSTACLE = 1'b1
    } box_role_t;

endpackage

@@ dv/amor_contact_checker.sv @@
`timescale 1ns / 1ps

module amor_contact_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    amor_box_if       box,
    amor_result_if    result,
    output int        errors,
    output int        pending,
    output int        hits
);

    localparam int CW = amor_pkg::COORD_W;
    localparam int SW = amor_pkg::SIZE_W;
    localparam int KW = amor_pkg::SCALE_W;
    localparam int PW = amor_pkg::PUSH_W;
    localparam int HS = amor_pkg::HALF_SHIFT;

    localparam longint COORD_LO = -(64'sd1 <<< (CW - 1));
    localparam longint COORD_HI = (64'sd1 <<< (CW - 1)) - 1;

    // one predicted contact
    typedef struct packed {
        amor_pkg::side_t           side;
        logic signed [PW-1:0]      push_x;
        logic signed [PW-1:0]      push_y;
        logic signed [PW-1:0]      push_z;
    } contact_t;

    contact_t          contact_q [$];
    amor_pkg::bounds_t mover_box;
    amor_pkg::bounds_t req_box;
    contact_t          want;
    int                err_n;
    int                hit_n;

    function automatic longint wide(input logic signed [CW-1:0] v);
        return longint'(v);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        if (v < COORD_LO)
            return COORD_LO[CW-1:0];
        if (v > COORD_HI)
            return COORD_HI[CW-1:0];
        return v[CW-1:0];
    endfunction

    // one axis: half extent is size * scale / 512, bounds saturate to 32 bits
    function automatic void axis_span(
        input  logic signed [CW-1:0] centre,
        input  logic [SW-1:0]        size,
        input  logic [KW-1:0]        scale,
        output logic signed [CW-1:0] lo,
        output logic signed [CW-1:0] hi
    );
        longint half;
        half = (longint'(size) * longint'(scale)) >>> HS;
        lo   = clamp_coord(wide(centre) - half);
        hi   = clamp_coord(wide(centre) + half);
    endfunction

    // minimum-penetration side and push offsets of an obstacle against the mover
    function automatic contact_t resolve_contact(
        input amor_pkg::bounds_t mv,
        input amor_pkg::bounds_t ob
    );
        contact_t c;
        longint   gap [6];
        longint   least;
        c = '0;
        if (wide(mv.max_x) < wide(ob.min_x) || wide(mv.max_y) < wide(ob.min_y) ||
            wide(mv.max_z) < wide(ob.min_z) || wide(ob.max_x) < wide(mv.min_x) ||
            wide(ob.max_y) < wide(mv.min_y) || wide(ob.max_z) < wide(mv.min_z))
            return c;
        gap[0] = wide(ob.max_z) - wide(mv.min_z);   // top
        gap[1] = wide(ob.min_z) - wide(mv.max_z);   // bottom
        gap[2] = wide(ob.min_y) - wide(mv.max_y);   // left
        gap[3] = wide(ob.max_y) - wide(mv.min_y);   // right
        gap[4] = wide(ob.max_x) - wide(mv.min_x);   // front
        gap[5] = wide(ob.min_x) - wide(mv.max_x);   // back
        for (int i = 0; i < 6; i++)
        begin
            if (gap[i] < 0)
                gap[i] = -gap[i];
        end
        least = gap[0];
        for (int i = 1; i < 6; i++)
        begin
            if (gap[i] < least)
                least = gap[i];
        end
        // every tied face writes its axis, the last one names the side
        if (gap[0] == least)
        begin
            c.push_z = PW'(-gap[0]);
            c.side   = amor_pkg::SIDE_TOP;
        end
        if (gap[1] == least)
        begin
            c.push_z = PW'(gap[1]);
            c.side   = amor_pkg::SIDE_BOTTOM;
        end
        if (gap[2] == least)
        begin
            c.push_y = PW'(-gap[2]);
            c.side   = amor_pkg::SIDE_LEFT;
        end
        if (gap[3] == least)
        begin
            c.push_y = PW'(gap[3]);
            c.side   = amor_pkg::SIDE_RIGHT;
        end
        if (gap[4] == least)
        begin
            c.push_x = PW'(gap[4]);
            c.side   = amor_pkg::SIDE_FRONT;
        end
        if (gap[5] == least)
        begin
            c.push_x = PW'(gap[5]);
            c.side   = amor_pkg::SIDE_BACK;
        end
        return c;
    endfunction

    // watch both channels: results are checked before new requests are predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_q.delete();
            mover_box = '0;
            err_n     = 0;
            hit_n     = 0;
            errors  <= 0;
            pending <= 0;
            hits    <= 0;
        end
        else
        begin
            // compare an accepted result with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (contact_q.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected result side %0d push %0d %0d %0d",
                             $time, result.hit_side, result.push_x,
                             result.push_y, result.push_z);
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (result.hit_side !== want.side || result.push_x !== want.push_x ||
                        result.push_y !== want.push_y || result.push_z !== want.push_z)
                    begin
                        err_n++;
                        $display("%0t: expected side %0d push %0d %0d %0d, got %0d %0d %0d %0d",
                                 $time, want.side, want.push_x, want.push_y,
                                 want.push_z, result.hit_side, result.push_x,
                                 result.push_y, result.push_z);
                    end
                    if (want.side != amor_pkg::SIDE_NONE)
                        hit_n++;
                end
            end

            // accepted box request: store mover or predict contact
            if (box.valid && box.ready)
            begin
                axis_span(box.pos_x, box.depth_x, box.scale_x, req_box.min_x, req_box.max_x);
                axis_span(box.pos_y, box.width_y, box.scale_y, req_box.min_y, req_box.max_y);
                axis_span(box.pos_z, box.height_z, box.scale_z, req_box.min_z, req_box.max_z);
                if (box.box_role == amor_tb_pkg::ROLE_MOVER)
                    mover_box = req_box;
                else
                    contact_q.push_back(resolve_contact(mover_box, req_box));
            end

            errors  <= err_n;
            pending <= contact_q.size();
            hits    <= hit_n;
        end
    end

endmodule

@@ dv/tb_aabb_min_overlap_resolver_unit.sv @@
`timescale 1ns / 1ps

module tb_aabb_min_overlap_resolver_unit;

    localparam int CW = amor_pkg::COORD_W;
    localparam int SW = amor_pkg::SIZE_W;
    localparam int KW = amor_pkg::SCALE_W;

    localparam int Q            = 1 << 16;
    localparam int N_RANDOM     = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [KW-1:0]          UNITY     = 16'd256;
    localparam logic [SW-1:0]          CUBE      = 31'(4 * Q);
    localparam logic signed [CW-1:0]   COORD_MIN = 32'sh80000000;
    localparam logic signed [CW-1:0]   COORD_MAX = 32'sh7FFFFFFF;
    localparam logic [SW-1:0]          SIZE_MAX  = 31'h7FFFFFFF;
    localparam logic [KW-1:0]          SCALE_MAX = 16'hFFFF;
    localparam logic [KW-1:0]          SCALE_LSB = 16'd1;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   hits;
    int   cycles     = 0;
    int   hold_left  = 0;
    int   burst_left = 0;
    int   movers     = 0;
    int   obstacles  = 0;

    logic signed [CW-1:0] mover_c [3] = '{0, 0, 0};

    amor_box_if    box_ch ();
    amor_result_if result_ch ();

    aabb_min_overlap_resolver_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .box    (box_ch),
        .result (result_ch)
    );

    amor_contact_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .box     (box_ch),
        .result  (result_ch),
        .errors  (errors),
        .pending (pending),
        .hits    (hits)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result backpressure: free stretches, long stalls and random toggling
    always @(posedge clk)
    begin
        if (hold_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    result_ch.ready <= 1'b1;
                    hold_left       <= $urandom_range(20, 80);
                end
                1:
                begin
                    result_ch.ready <= 1'b0;
                    hold_left       <= $urandom_range(1, 12);
                end
                default:
                begin
                    result_ch.ready <= 1'($urandom_range(0, 1));
                    hold_left       <= $urandom_range(0, 6);
                end
            endcase
        end
        else
            hold_left <= hold_left - 1;
    end

    // one box request, sent in bursts with random gaps between them
    task automatic send_box(
        input amor_tb_pkg::box_role_t role,
        input logic signed [CW-1:0]   px, py, pz,
        input logic [SW-1:0]          sx, sy, sz,
        input logic [KW-1:0]          kx, ky, kz
    );
        if (burst_left == 0)
        begin
            box_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        box_ch.valid    <= 1'b1;
        box_ch.box_role <= role;
        box_ch.pos_x    <= px;
        box_ch.pos_y    <= py;
        box_ch.pos_z    <= pz;
        box_ch.depth_x  <= sx;
        box_ch.width_y  <= sy;
        box_ch.height_z <= sz;
        box_ch.scale_x  <= kx;
        box_ch.scale_y  <= ky;
        box_ch.scale_z  <= kz;
        @(posedge clk);
        while (!box_ch.ready)
            @(posedge clk);
        if (role == amor_tb_pkg::ROLE_MOVER)
        begin
            mover_c = '{px, py, pz};
            movers++;
        end
        else
            obstacles++;
    endtask

    // faces, ties, touching, zero scale and saturation
    task automatic directed_boxes();
        logic signed [CW-1:0] p [3];
        // point obstacle against the reset mover ties on every face
        send_box(amor_tb_pkg::ROLE_OBSTACLE, 0, 0, 0, '0, '0, '0, UNITY, UNITY, UNITY);
        // clear miss against the reset mover
        send_box(amor_tb_pkg::ROLE_OBSTACLE, 10 * Q, 0, 0, CUBE, CUBE, CUBE,
                 UNITY, UNITY, UNITY);
        // cube mover of side 4 at the origin
        send_box(amor_tb_pkg::ROLE_MOVER, 0, 0, 0, CUBE, CUBE, CUBE, UNITY, UNITY, UNITY);
        // shallow overlap past each face in turn
        for (int a = 0; a < 3; a++)
        begin
            for (int sgn = -1; sgn <= 1; sgn += 2)
            begin
                p    = '{0, 0, 0};
                p[a] = sgn * 3 * Q;
                send_box(amor_tb_pkg::ROLE_OBSTACLE, p[0], p[1], p[2], CUBE, CUBE, CUBE,
                         UNITY, UNITY, UNITY);
            end
        end
        // corner overlap ties two faces on different axes
        send_box(amor_tb_pkg::ROLE_OBSTACLE, 3 * Q, 3 * Q, 0, CUBE, CUBE, CUBE,
                 UNITY, UNITY, UNITY);
        // identical box ties all six faces
        send_box(amor_tb_pkg::ROLE_OBSTACLE, 0, 0, 0, CUBE, CUBE, CUBE, UNITY, UNITY, UNITY);
        // zero scale shrinks the obstacle to a point inside
        send_box(amor_tb_pkg::ROLE_OBSTACLE, Q, -Q, Q, CUBE, CUBE, CUBE, '0, '0, '0);
        // faces exactly touching
        send_box(amor_tb_pkg::ROLE_OBSTACLE, 4 * Q, 0, 0, CUBE, CUBE, CUBE,
                 UNITY, UNITY, UNITY);
        // huge obstacles saturate on both sides
        send_box(amor_tb_pkg::ROLE_OBSTACLE, COORD_MIN, COORD_MIN, COORD_MIN,
                 SIZE_MAX, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        send_box(amor_tb_pkg::ROLE_OBSTACLE, COORD_MAX, COORD_MAX, COORD_MAX,
                 SIZE_MAX, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        // saturated mover at the positive corner
        send_box(amor_tb_pkg::ROLE_MOVER, COORD_MAX, COORD_MAX, COORD_MAX,
                 SIZE_MAX, SIZE_MAX, SIZE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX);
        send_box(amor_tb_pkg::ROLE_OBSTACLE, COORD_MAX, COORD_MAX, COORD_MAX,
                 '0, '0, '0, '0, '0, '0);
        send_box(amor_tb_pkg::ROLE_OBSTACLE, COORD_MIN, COORD_MIN, COORD_MIN,
                 '0, '0, '0, '0, '0, '0);
        send_box(amor_tb_pkg::ROLE_OBSTACLE, -1, -1, -1, SIZE_MAX, SIZE_MAX, SIZE_MAX,
                 SCALE_LSB, SCALE_LSB, SCALE_LSB);
        // small mover back at the origin
        send_box(amor_tb_pkg::ROLE_MOVER, 0, 0, 0, CUBE, CUBE, CUBE, UNITY, UNITY, UNITY);
    endtask

    // random box: mostly grid-aligned near the mover, some full-range noise
    task automatic random_box();
        amor_tb_pkg::box_role_t role;
        int                     mode;
        logic signed [CW-1:0]   p [3];
        logic [SW-1:0]          s [3];
        logic [KW-1:0]          k [3];
        role = ($urandom_range(0, 7) == 0) ? amor_tb_pkg::ROLE_MOVER
                                           : amor_tb_pkg::ROLE_OBSTACLE;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            case (mode)
                7:
                begin
                    p[a] = $urandom;
                    s[a] = SW'($urandom);
                    k[a] = KW'($urandom);
                end
                8:
                begin
                    case ($urandom_range(0, 3))
                        0:       p[a] = COORD_MIN;
                        1:       p[a] = COORD_MAX;
                        2:       p[a] = 0;
                        default: p[a] = -1;
                    endcase
                    s[a] = $urandom_range(0, 1) ? SIZE_MAX : SW'($urandom_range(0, 2));
                    k[a] = $urandom_range(0, 1) ? SCALE_MAX : KW'($urandom_range(0, 2));
                end
                9:
                begin
                    p[a] = mover_c[a] + $urandom_range(0, 4 * Q) - 2 * Q;
                    s[a] = SW'($urandom);
                    k[a] = KW'($urandom_range(0, 256));
                end
                default:
                begin
                    if (role == amor_tb_pkg::ROLE_MOVER)
                        p[a] = (int'($urandom_range(0, 16)) - 8) * Q;
                    else
                        p[a] = mover_c[a] + (int'($urandom_range(0, 16)) - 8) * (Q / 2);
                    s[a] = SW'($urandom_range(0, 16) * (Q / 2));
                    case ($urandom_range(0, 3))
                        0:       k[a] = UNITY;
                        1:       k[a] = UNITY << 1;
                        2:       k[a] = UNITY >> 1;
                        default: k[a] = KW'($urandom_range(0, 1023));
                    endcase
                end
            endcase
        end
        send_box(role, p[0], p[1], p[2], s[0], s[1], s[2], k[0], k[1], k[2]);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n           <= 1'b0;
        box_ch.valid    <= 1'b0;
        box_ch.box_role <= amor_tb_pkg::ROLE_MOVER;
        box_ch.pos_x    <= '0;
        box_ch.pos_y    <= '0;
        box_ch.pos_z    <= '0;
        box_ch.depth_x  <= '0;
        box_ch.width_y  <= '0;
        box_ch.height_z <= '0;
        box_ch.scale_x  <= '0;
        box_ch.scale_y  <= '0;
        box_ch.scale_z  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed_boxes();
        repeat (N_RANDOM) random_box();

        // drain outstanding contacts
        box_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d box requests: %0d movers, %0d obstacles; %0d obstacles hit",
                 movers + obstacles, movers, obstacles, hits);
        $display("covered every face, tied faces, touching, zero scale and saturated bounds");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/amor_pkg.sv
hw/rtl/amor_if.sv
hw/rtl/amor_box_bounds.sv
hw/rtl/aabb_min_overlap_resolver_unit.sv
dv/amor_tb_pkg.sv
dv/amor_contact_checker.sv
dv/tb_aabb_min_overlap_resolver_unit.sv
